FILE: design/afc_pkg.sv
`default_nettype none

package afc_pkg;

  localparam int FRAME_DATA_BYTES = 8;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

  // One data byte with the header context it decodes under.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] scale;
    logic [3:0] pred;
    logic       fresh;      // history starts from zero at the high nibble
    logic       frame_end;  // last data byte of its frame
  } afc_entry_t;

  typedef struct packed {
    logic signed [13:0] c0;
    logic signed [13:0] c1;
  } afc_coef_t;

  // Predictor coefficient pairs, signed Q11.
  function automatic afc_coef_t afc_coef(input logic [3:0] idx);
    afc_coef_t c;
    unique case (idx)
      4'd0:  c = '{ 14'sd0,     14'sd0    };
      4'd1:  c = '{ 14'sd2048,  14'sd0    };
      4'd2:  c = '{ 14'sd0,     14'sd2048 };
      4'd3:  c = '{ 14'sd1024,  14'sd1024 };
      4'd4:  c = '{ 14'sd4096, -14'sd2048 };
      4'd5:  c = '{ 14'sd3584, -14'sd1536 };
      4'd6:  c = '{ 14'sd3072, -14'sd1024 };
      4'd7:  c = '{ 14'sd4608, -14'sd2560 };
      4'd8:  c = '{ 14'sd4200, -14'sd2248 };
      4'd9:  c = '{ 14'sd4800, -14'sd2300 };
      4'd10: c = '{ 14'sd5120, -14'sd3072 };
      4'd11: c = '{ 14'sd2048, -14'sd2048 };
      4'd12: c = '{ 14'sd1024, -14'sd1024 };
      4'd13: c = '{-14'sd1024,  14'sd1024 };
      4'd14: c = '{-14'sd1024,  14'sd0    };
      4'd15: c = '{-14'sd2048,  14'sd0    };
      default: c = '{ 14'sd0,   14'sd0    };
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/afc_front.sv
`default_nettype none

module afc_front import afc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       new_stream,
  input  wire logic       q_ready,
  output logic            q_push,
  output afc_entry_t      q_entry
);

  logic [3:0] frame_position;
  logic [3:0] frame_position_next;
  logic [3:0] scale;
  logic [3:0] pred;
  logic       clr_pend;
  logic [3:0] pos_eff;
  logic       is_header;
  logic       frame_end;
  logic       accept;

  always_comb begin
    in_ready  = q_ready;
    accept    = in_valid && in_ready;
    pos_eff   = new_stream ? 4'd0 : frame_position;
    is_header = (pos_eff == 4'd0) || (pos_eff > 4'(FRAME_DATA_BYTES));
    frame_end = (pos_eff == 4'(FRAME_DATA_BYTES));
    q_push    = accept && !is_header;
    q_entry.data_byte = data_byte;
    q_entry.scale     = scale;
    q_entry.pred      = pred;
    q_entry.fresh     = clr_pend || new_stream;
    q_entry.frame_end = frame_end;
    if (is_header) begin
      frame_position_next = 4'd1;
    end else if (frame_end) begin
      frame_position_next = 4'd0;
    end else begin
      frame_position_next = pos_eff + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= 4'd0;
      scale          <= 4'd0;
      pred           <= 4'd0;
      clr_pend       <= 1'b0;
    end else if (accept) begin
      frame_position <= frame_position_next;
      if (is_header) begin
        scale    <= data_byte[7:4];
        pred     <= data_byte[3:0];
        clr_pend <= clr_pend || new_stream;
      end else begin
        clr_pend <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/afc_queue.sv
`default_nettype none

module afc_queue import afc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire afc_entry_t push_entry,
  output logic            push_ready,
  input  wire logic       pop,
  output logic            pop_valid,
  output afc_entry_t      pop_entry
);

  afc_entry_t          mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  always_comb begin
    push_ready = (count != QCNT_W'(QDEPTH));
    pop_valid  = (count != '0);
    pop_entry  = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/afc_back.sv
`default_nettype none

module afc_back import afc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire afc_entry_t  q_entry,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] sample,
  output logic             last_of_byte,
  output logic             end_of_frame
);

  logic signed [15:0] newest;
  logic signed [15:0] older;
  logic               phase;     // 0: high nibble, 1: low nibble
  logic               adv;
  logic               fire;
  logic [3:0]         nib;
  afc_coef_t          coef;
  logic signed [15:0] h1;
  logic signed [15:0] h2;
  logic signed [31:0] step;
  logic signed [29:0] p0;
  logic signed [29:0] p1;
  logic signed [31:0] acc;
  logic signed [20:0] q;
  logic signed [15:0] q_sat;

  always_comb begin
    adv   = !out_valid || out_ready;
    fire  = q_valid && adv;
    q_pop = fire && phase;
    nib   = phase ? q_entry.data_byte[3:0] : q_entry.data_byte[7:4];
    coef  = afc_coef(q_entry.pred);
    if (!phase && q_entry.fresh) begin
      h1 = '0;
      h2 = '0;
    end else begin
      h1 = newest;
      h2 = older;
    end
    // nibble * 2^scale * 2048; at most 2^29 in magnitude
    step = ({{28{nib[3]}}, nib} <<< q_entry.scale) <<< 11;
    p0   = h1 * coef.c0;
    p1   = h2 * coef.c1;
    acc  = step + 32'(p0) + 32'(p1);
    q    = 21'(acc >>> 11);
    if (q > 21'(SAMPLE_MAX)) begin
      q_sat = SAMPLE_MAX;
    end else if (q < 21'(SAMPLE_MIN)) begin
      q_sat = SAMPLE_MIN;
    end else begin
      q_sat = q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
      newest    <= '0;
      older     <= '0;
    end else begin
      if (adv) begin
        out_valid <= q_valid;
      end
      if (fire) begin
        phase  <= ~phase;
        older  <= h1;
        newest <= q_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sample       <= q_sat;
      last_of_byte <= phase;
      end_of_frame <= phase && q_entry.frame_end;
    end
  end

endmodule

`default_nettype wire

FILE: design/afc_adpcm_frame_decoder.sv
// A data byte's beat passes through the byte queue and the registered output stage before its first sample beat.
// Each data byte yields two samples, one sample per cycle while out_ready holds; header bytes yield none.
// Sample throughput is set by the sample datapath, where each nibble's prediction needs the previous sample.
// Reset (rst, synchronous, active high) clears history, frame position, header fields,
// the byte queue and the output valid.
`default_nettype none

module afc_adpcm_frame_decoder import afc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        new_stream,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] sample,
  output logic             last_of_byte,
  output logic             end_of_frame
);

  // Front: tracks frame position and header, tags each data byte with its context.
  afc_entry_t fq_entry;
  logic       fq_push;
  logic       fq_ready;

  // Back side of the byte queue.
  afc_entry_t bq_entry;
  logic       bq_valid;
  logic       bq_pop;

  afc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .new_stream (new_stream),
    .q_ready    (fq_ready),
    .q_push     (fq_push),
    .q_entry    (fq_entry)
  );

  // Two-entry queue lets the front keep taking beats while samples wait downstream.
  afc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fq_push),
    .push_entry (fq_entry),
    .push_ready (fq_ready),
    .pop        (bq_pop),
    .pop_valid  (bq_valid),
    .pop_entry  (bq_entry)
  );

  // Back: one nibble per cycle while the output is not stalled, history update, registered output beat.
  afc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (bq_valid),
    .q_entry      (bq_entry),
    .q_pop        (bq_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample       (sample),
    .last_of_byte (last_of_byte),
    .end_of_frame (end_of_frame)
  );

endmodule

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

module tb;
  import afc_pkg::*;

  // Beats past the directed script; no new frame is started once this many have gone in.
  localparam int RANDOM_ITEMS = 1030;
  localparam int DRAIN_LIMIT  = 4000;   // cycles allowed for the tail of the run
  localparam int IDLE_PCT     = 17;

  // Predictor coefficient pairs, signed Q11, indexed by the header's low nibble.
  localparam int PRED_C0 [16] = '{    0, 2048,    0, 1024, 4096,  3584,  3072,  4608,
                                   4200, 4800, 5120, 2048, 1024, -1024, -1024, -2048};
  localparam int PRED_C1 [16] = '{    0,     0, 2048,  1024, -2048, -1536, -1024, -2560,
                                  -2248, -2300, -3072, -2048, -1024,  1024,     0,     0};

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         data_byte;
  logic               new_stream;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] sample;
  logic               last_of_byte;
  logic               end_of_frame;

  afc_adpcm_frame_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .new_stream   (new_stream),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample       (sample),
    .last_of_byte (last_of_byte),
    .end_of_frame (end_of_frame)
  );

  // One decoded PCM beat as the output channel should carry it.
  typedef struct {
    logic signed [15:0] pcm;
    logic               second;
    logic               frame_end;
  } pcm_beat_t;

  // Directed script row; known=1 means the two samples are typed in below.
  typedef struct packed {
    logic [7:0]         b;
    logic               ns;
    logic               known;
    logic signed [15:0] hi;
    logic signed [15:0] lo;
  } script_row_t;

  localparam int SCRIPT_LEN = 21;

  pcm_beat_t   pcm_due[$];   // samples still owed by the decoder, oldest first
  script_row_t script [SCRIPT_LEN];

  // Decoder state as the predictor sees it.
  logic signed [15:0] hist_new;
  logic signed [15:0] hist_old;
  logic [3:0]         frame_pos;
  logic [3:0]         cur_scale;
  logic [3:0]         cur_pred;

  int  errs;
  int  beats_in;
  int  pcm_seen;
  int  frames_seen;
  int  clipped_seen;
  bit  steady;     // no idling on either side while set

  // ------------------------------------------------------------------
  // Clock and reset
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop, far beyond any correct run.
  initial begin
    #2_000_000;
    $display("afc_adpcm_frame_decoder: mismatch");
    $finish;
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  // One nibble through the Q11 predictor: full-precision step, floor shift, clip.
  function automatic logic signed [15:0] nibble_pcm(input logic [3:0] nib,
                                                   input logic [3:0] scl,
                                                   input logic [3:0] idx,
                                                   input logic signed [15:0] h1,
                                                   input logic signed [15:0] h2);
    longint acc;
    longint q;
    // scale 15 gives a step of 32768 per nibble unit; longint keeps it from wrapping
    acc = longint'($signed(nib)) <<< (int'(scl) + 11);
    acc += longint'(h1) * PRED_C0[idx] + longint'(h2) * PRED_C1[idx];
    q = acc >>> 11;
    if (q > longint'(SAMPLE_MAX)) q = SAMPLE_MAX;
    if (q < longint'(SAMPLE_MIN)) q = SAMPLE_MIN;
    return q[15:0];
  endfunction

  // Advances the predicted state by one stream byte; has_pcm says whether
  // the byte was a data byte (two samples) or a header (none).
  task automatic predict_byte(input logic [7:0] b, input logic ns, output bit has_pcm,
                              output pcm_beat_t hi, output pcm_beat_t lo);
    logic closing;
    if (ns) begin
      hist_new  = '0;
      hist_old  = '0;
      frame_pos = '0;
    end
    has_pcm = 1'b0;
    if (frame_pos == 0 || frame_pos > FRAME_DATA_BYTES) begin
      cur_scale = b[7:4];
      cur_pred  = b[3:0];
      frame_pos = 4'd1;
    end else begin
      has_pcm   = 1'b1;
      closing   = (frame_pos == FRAME_DATA_BYTES);
      hi.pcm    = nibble_pcm(b[7:4], cur_scale, cur_pred, hist_new, hist_old);
      hist_old  = hist_new;
      hist_new  = hi.pcm;
      hi.second    = 1'b0;
      hi.frame_end = 1'b0;
      lo.pcm    = nibble_pcm(b[3:0], cur_scale, cur_pred, hist_new, hist_old);
      hist_old  = hist_new;
      hist_new  = lo.pcm;
      lo.second    = 1'b1;
      lo.frame_end = closing;
      frame_pos = closing ? 4'd0 : frame_pos + 4'd1;
    end
  endtask

  // ------------------------------------------------------------------
  // Input side: one beat per call, entered and left at a falling edge
  // ------------------------------------------------------------------
  task automatic feed_byte(input logic [7:0] b, input logic ns, input bit known,
                           input logic signed [15:0] hi_pcm, input logic signed [15:0] lo_pcm);
    bit        has_pcm;
    pcm_beat_t hi;
    pcm_beat_t lo;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    new_stream <= ns;
    do @(posedge clk); while (!in_ready);
    // beat taken at this edge
    predict_byte(b, ns, has_pcm, hi, lo);
    if (has_pcm) begin
      if (known) begin
        hi.pcm = hi_pcm;
        lo.pcm = lo_pcm;
      end
      pcm_due.push_back(hi);
      pcm_due.push_back(lo);
    end
    beats_in++;
    @(negedge clk);
  endtask

  // Sender holds off until the decoder owes nothing.
  task automatic drain_pause();
    in_valid <= 1'b0;
    do @(negedge clk); while (pcm_due.size() != 0);
  endtask

  // ------------------------------------------------------------------
  // Output side: random back-pressure, checker
  // ------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : pcm_check
    pcm_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pcm_due.size() == 0) begin
        $error("sample beat with nothing owed: sample %0d", sample);
        errs++;
      end else begin
        want = pcm_due.pop_front();
        pcm_seen++;
        if (sample !== want.pcm) begin
          $error("sample: expected %0d, got %0d", want.pcm, sample);
          errs++;
        end
        if (last_of_byte !== want.second) begin
          $error("last_of_byte: expected %0b, got %0b", want.second, last_of_byte);
          errs++;
        end
        if (end_of_frame !== want.frame_end) begin
          $error("end_of_frame: expected %0b, got %0b", want.frame_end, end_of_frame);
          errs++;
        end
        if (want.frame_end) frames_seen++;
        if (want.pcm == SAMPLE_MAX || want.pcm == SAMPLE_MIN) clipped_seen++;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  initial begin : stimulus
    int          guard;
    int          ndata;
    int          goal;
    logic [7:0]  hdr;
    bit          paused;

    rst        = 1'b1;
    in_valid   = 1'b0;
    data_byte  = '0;
    new_stream = 1'b0;
    out_ready  = 1'b0;
    steady     = 1'b0;
    paused     = 1'b0;
    errs = 0; beats_in = 0; pcm_seen = 0; frames_seen = 0; clipped_seen = 0;
    hist_new = '0; hist_old = '0; frame_pos = '0; cur_scale = '0; cur_pred = '0;

    //            byte   ns    known  high     low
    script = '{
      '{8'h00, 1'b0, 1'b0,      0,      0},   // header: scale 0, no prediction
      '{8'h7f, 1'b0, 1'b1,      7,     -1},   // largest and smallest nonzero nibbles
      '{8'h80, 1'b0, 1'b1,     -8,      0},
      '{8'hf0, 1'b1, 1'b0,      0,      0},   // fresh stream, scale 15
      '{8'h17, 1'b0, 1'b1,  32767,  32767},   // step 32768 must clip, not wrap
      '{8'h8f, 1'b0, 1'b1, -32768, -32768},
      '{8'h35, 1'b1, 1'b0,      0,      0},   // fresh flag mid-frame: byte is a header
      '{8'h7f, 1'b0, 1'b0,      0,      0},
      '{8'h80, 1'b0, 1'b0,      0,      0},
      '{8'h19, 1'b0, 1'b0,      0,      0},
      '{8'he2, 1'b0, 1'b0,      0,      0},
      '{8'h00, 1'b0, 1'b0,      0,      0},
      '{8'hff, 1'b0, 1'b0,      0,      0},
      '{8'h5a, 1'b0, 1'b0,      0,      0},
      '{8'ha5, 1'b0, 1'b0,      0,      0},   // eighth data byte closes the frame
      '{8'he9, 1'b0, 1'b0,      0,      0},   // large scale, negative c1: floor shift
      '{8'h71, 1'b0, 1'b0,      0,      0},
      '{8'h9e, 1'b0, 1'b0,      0,      0},
      '{8'h44, 1'b0, 1'b0,      0,      0},
      '{8'h00, 1'b1, 1'b0,      0,      0},   // fresh stream back to scale 0
      '{8'h88, 1'b0, 1'b1,     -8,     -8}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i])
      feed_byte(script[i].b, script[i].ns, script[i].known, script[i].hi, script[i].lo);

    // Random part: mostly whole frames with random headers and payload,
    // with fresh-stream flags, cut-short frames and stray flags mixed in.
    goal = beats_in + RANDOM_ITEMS;
    while (beats_in < goal) begin
      steady = (beats_in >= goal - 700 && beats_in < goal - 520);
      if (!paused && beats_in >= goal - 400) begin
        drain_pause();
        paused = 1'b1;
      end
      hdr[7:4] = $urandom_range(1) ? 4'($urandom_range(15)) : 4'($urandom_range(6));
      hdr[3:0] = 4'($urandom_range(15));
      feed_byte(hdr, ($urandom_range(7) == 0), 1'b0, 0, 0);
      ndata = ($urandom_range(9) == 0) ? $urandom_range(7) : FRAME_DATA_BYTES;
      for (int k = 0; k < ndata; k++)
        feed_byte(8'($urandom_range(255)), ($urandom_range(59) == 0), 1'b0, 0, 0);
    end
    steady = 1'b0;

    // Tail: let every owed sample come out, then a few quiet cycles.
    in_valid <= 1'b0;
    guard = 0;
    while (pcm_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
    if (pcm_due.size() != 0) begin
      $error("%0d samples never came out", pcm_due.size());
      errs++;
    end

    $display("run: %0d stream bytes in, %0d samples checked", beats_in, pcm_seen);
    $display("run: %0d whole frames closed, %0d samples at the clip limits",
             frames_seen, clipped_seen);
    if (errs == 0) begin
      $display("afc_adpcm_frame_decoder: match");
    end else begin
      $display("afc_adpcm_frame_decoder: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: afc_adpcm_frame_decoder.f
design/afc_pkg.sv
design/afc_front.sv
design/afc_queue.sv
design/afc_back.sv
design/afc_adpcm_frame_decoder.sv
sim/tb.sv
